FILE: hw/rtl/ncs_pkg.sv
// Shared widths and helpers for the NTSC line comb separator.
package ncs_pkg;

  localparam int unsigned SampleW    = 8;
  localparam int unsigned PhaseW     = 2;
  localparam int unsigned LumaW      = 10;
  localparam int unsigned ChromaW    = 10;
  localparam int unsigned CombLinesW = 2;
  localparam int unsigned LineLength = 910;

  // Reset value of comb_lines: one-line comb.
  localparam logic [CombLinesW-1:0] CombLinesReset = CombLinesW'(1);

  // Chroma is negated at phases 1 and 2, kept at phases 0 and 3.
  function automatic logic chroma_negate(input logic [PhaseW-1:0] phase);
    return phase[0] ^ phase[1];
  endfunction

  // Phase 1 and 3 carry I, phase 0 and 2 carry Q.
  function automatic logic phase_is_i(input logic [PhaseW-1:0] phase);
    return phase[0];
  endfunction

endpackage

FILE: hw/rtl/ncs_ifs.sv
// Valid/ready channel interfaces of the NTSC line comb separator.
interface ncs_in_if;
  import ncs_pkg::*;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic [PhaseW-1:0]  phase;
  modport source (output valid, output sample, output phase, input ready);
  modport sink   (input valid, input sample, input phase, output ready);
endinterface

interface ncs_out_if;
  import ncs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [LumaW-1:0]          luma;
  logic signed [ChromaW-1:0] chroma;
  logic                      chroma_is_i;
  modport source (output valid, output luma, output chroma, output chroma_is_i, input ready);
  modport sink   (input valid, input luma, input chroma, input chroma_is_i, output ready);
endinterface

interface ncs_cfg_if;
  import ncs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CombLinesW-1:0] comb_lines;
  modport source (output valid, output comb_lines, input ready);
  modport sink   (input valid, input comb_lines, output ready);
endinterface

FILE: hw/rtl/ncs_ram.sv
// Generic simple dual-port RAM with registered read.
module ncs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ntsc_line_comb_separator.sv
// NTSC line comb separator: splits 4x-subcarrier composite words into luma and chroma.
// One word is taken every clock and each gives one result word at the output register; a full
// pipeline stalls only when the output word is not taken. Both line delays share one RAM of
// LINE_LENGTH x 16 bits, read when a word enters and written back one stage later, so the
// single read and write port set the rate of one word per clock. There is no clearing pass:
// until the write pointer has wrapped once, the delay taps read as zero, so the block takes
// words right out of reset. comb_lines bit 1 picks the two-line comb, else the one-line comb.
module ntsc_line_comb_separator #(
  parameter int unsigned LINE_LENGTH = ncs_pkg::LineLength
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ncs_cfg_if.sink   cfg_i,
  ncs_in_if.sink    in_i,
  ncs_out_if.source out_o
);
  import ncs_pkg::*;

  localparam int unsigned PtrW  = $clog2(LINE_LENGTH);
  localparam int unsigned WordW = 2 * SampleW;
  localparam int unsigned DiffW = ChromaW + 1;

  logic [CombLinesW-1:0] comb_lines_q;
  logic [PtrW-1:0]       ptr_q, ptr_d;
  logic                  filled_q, filled_d;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic in_acc;

  // stage 1: RAM read in flight
  logic [SampleW-1:0] cur1_q;
  logic [PhaseW-1:0]  phase1_q;
  logic [PtrW-1:0]    ptr1_q;
  logic               filled1_q;
  logic [WordW-1:0]   rdata;
  logic [SampleW-1:0] prev1, oldest1;

  // stage 2: comb arithmetic done
  logic [LumaW-1:0]          luma2_q, luma2_d;
  logic signed [ChromaW-1:0] diff2_q, diff2_d;
  logic [PhaseW-1:0]         phase2_q;

  // stage 3: output register
  logic [LumaW-1:0]          luma3_q;
  logic signed [ChromaW-1:0] chroma3_q, chroma3_d;
  logic                      is_i3_q;

  logic signed [DiffW-1:0] prev_s, oldest_s, cur_s, diff_wide;

  // Ready chain: a stage loads when it is empty or its word moves on.
  assign rdy3   = !v3_q || out_o.ready;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign in_acc = in_i.valid && rdy1;

  assign in_i.ready  = rdy1;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comb_lines_q <= CombLinesReset;
    end else if (cfg_i.valid) begin
      comb_lines_q <= cfg_i.comb_lines;
    end
  end

  always_comb begin
    ptr_d    = ptr_q;
    filled_d = filled_q;
    if (in_acc) begin
      if (ptr_q == PtrW'(LINE_LENGTH - 1)) begin
        ptr_d    = '0;
        filled_d = 1'b1;
      end else begin
        ptr_d = ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      filled_q <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
    end else begin
      ptr_q    <= ptr_d;
      filled_q <= filled_d;
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Word layout: line two back in the upper byte, line one back in the lower byte.
  ncs_ram #(
    .Width (WordW),
    .Depth (LINE_LENGTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (v1_q && rdy2),
    .waddr_i (ptr1_q),
    .wdata_i ({prev1, cur1_q}),
    .re_i    (in_acc),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  // Entries not yet written on the first pass read as the cleared value.
  assign prev1   = filled1_q ? rdata[SampleW-1:0]     : '0;
  assign oldest1 = filled1_q ? rdata[WordW-1:SampleW] : '0;

  assign prev_s   = $signed({{(DiffW-SampleW){1'b0}}, prev1});
  assign oldest_s = $signed({{(DiffW-SampleW){1'b0}}, oldest1});
  assign cur_s    = $signed({{(DiffW-SampleW){1'b0}}, cur1_q});

  always_comb begin
    if (comb_lines_q[1]) begin
      luma2_d   = {prev1, 2'b00};
      diff_wide = (prev_s <<< 1) - oldest_s - cur_s;
    end else begin
      luma2_d   = {1'b0, prev1, 1'b0};
      diff_wide = prev_s - cur_s;
    end
    diff2_d = diff_wide[ChromaW-1:0];
  end

  assign chroma3_d = chroma_negate(phase2_q) ? -diff2_q : diff2_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur1_q    <= in_i.sample;
      phase1_q  <= in_i.phase;
      ptr1_q    <= ptr_q;
      filled1_q <= filled_q;
    end
    if (rdy2 && v1_q) begin
      luma2_q  <= luma2_d;
      diff2_q  <= diff2_d;
      phase2_q <= phase1_q;
    end
    if (rdy3 && v2_q) begin
      luma3_q   <= luma2_q;
      chroma3_q <= chroma3_d;
      is_i3_q   <= phase_is_i(phase2_q);
    end
  end

  assign out_o.valid       = v3_q;
  assign out_o.luma        = luma3_q;
  assign out_o.chroma      = chroma3_q;
  assign out_o.chroma_is_i = is_i3_q;

endmodule

FILE: hw/rtl/ncs_checker.sv
// Port-level checks for the NTSC line comb separator, bound to the top level.
module ncs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] luma,
  input logic [9:0] chroma
);

  // Output word holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(luma) && $stable(chroma))
    else $error("output word changed or dropped while stalled");

  // Input is only back-pressured by a stalled, full output.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output side is free");

  // A taken word reaches the output register when the sink keeps up.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result word missing three clocks after input");

  // Luma is always an even multiple of the delayed sample.
  a_luma_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !luma[0])
    else $error("odd luma value");

endmodule

bind ntsc_line_comb_separator ncs_checker u_ncs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .luma      (out_o.luma),
  .chroma    (out_o.chroma)
);
